// ----- design/mms_pkg.sv -----
package mms_pkg;

   // widths fixed by the item formats
   localparam int DATA_W          = 32;
   localparam int COUNT_W         = 7;
   localparam int MODE_W          = 2;
   localparam int RSP_DATA_W      = 48;
   localparam int MAX_SAMPLES_DEF = 64;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STATISTIC_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_VALUE    = 4'd1;

   // statistic modes
   localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UPPER  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAD    = 2'd2;

   // mad scale 1.4826 as q1.14, rounded half up
   localparam int MAD_SCALE_W = 15;
   localparam int MAD_SHIFT   = 14;
   localparam logic [MAD_SCALE_W-1:0] MAD_SCALE = 15'd24291;
   localparam logic [MAD_SHIFT-1:0]   MAD_HALF  = 14'd8192;

   // largest positive value
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [1:0] {
      ALU_GT,
      ALU_MEAN,
      ALU_DEV
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              flag;
   } alu_rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic              has_sample;
      logic              last;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0]  result_value;
      logic [COUNT_W-1:0] sample_count;
      logic               overflowed;
      logic               saturated;
   } rsp_item_type;

endpackage

// ----- design/mms_ram.sv -----
module mms_ram #(
   parameter int WIDTH = mms_pkg::DATA_W,
   parameter int DEPTH = mms_pkg::MAX_SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/mms_alu.sv -----
module mms_alu (
   input  mms_pkg::alu_req_type req,
   output mms_pkg::alu_rsp_type rsp
);

   localparam int W = mms_pkg::DATA_W;

   logic signed [W:0] a_ext;
   logic signed [W:0] b_ext;
   logic signed [W:0] sum;
   logic signed [W:0] diff;
   logic        [W:0] mag;
   logic              dev_sat;

   // combinational alu: compare, floor mean, saturated absolute difference
   always_comb begin
      a_ext   = {req.a[W-1], req.a};
      b_ext   = {req.b[W-1], req.b};
      sum     = a_ext + b_ext;
      diff    = a_ext - b_ext;
      mag     = diff[W] ? -diff : diff;
      dev_sat = |mag[W:W-1];
      rsp.value = req.a;
      rsp.flag  = 1'b0;
      unique case (req.op)
         mms_pkg::ALU_GT: begin
            rsp.flag = $signed(req.a) > $signed(req.b);
         end
         mms_pkg::ALU_MEAN: begin
            rsp.value = sum[W:1];
         end
         mms_pkg::ALU_DEV: begin
            rsp.flag  = dev_sat;
            rsp.value = dev_sat ? mms_pkg::SAT_MAX : mag[W-1:0];
         end
         default: begin
            rsp.value = req.a;
         end
      endcase
   end

endmodule

// ----- design/mms_seq.sv -----
module mms_seq #(
   parameter int MAX_SAMPLES = mms_pkg::MAX_SAMPLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  mms_pkg::req_item_type          in_item,
   output logic                           in_ready,
   input  logic [mms_pkg::MODE_W-1:0]     mode,
   input  logic [mms_pkg::DATA_W-1:0]     empty_value,
   output logic                           res_valid,
   input  logic                           res_ready,
   output mms_pkg::rsp_item_type          res_item
);

   localparam int DW     = mms_pkg::DATA_W;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int PROD_W = DW + mms_pkg::MAD_SCALE_W + 1;
   localparam int SH     = mms_pkg::MAD_SHIFT;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_FIN,
      S_MED_RDH,
      S_MED_RDL,
      S_MED_CALC,
      S_DEV_FIRST,
      S_DEV_LAST,
      S_DEV_LO,
      S_DEV_HI,
      S_POP,
      S_FETCH_L,
      S_FETCH_R,
      S_DMED,
      S_SCALE,
      S_ROUND,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              sat_ff, sat_in;
   logic              last_ff, last_in;
   logic [DW-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [DW-1:0]     hi_ff, hi_in;
   logic [DW-1:0]     lo_ff, lo_in;
   logic [DW-1:0]     med_ff, med_in;
   logic [DW-1:0]     dl_ff, dl_in;
   logic [DW-1:0]     dr_ff, dr_in;
   logic [CNT_W-1:0]  lcnt_ff, lcnt_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [DW-1:0]     dlo_ff, dlo_in;
   logic [DW-1:0]     dhi_ff, dhi_in;
   logic [DW-1:0]     dm_ff, dm_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DW-1:0]     result_ff, result_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DW-1:0]     wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DW-1:0]     rd_data;

   mms_pkg::alu_req_type alu_req;
   mms_pkg::alu_rsp_type alu_rsp;

   logic [CNT_W-1:0] half;
   logic [CNT_W-1:0] half_m1;
   logic [CNT_W-1:0] n_m1;
   logic [CNT_W-1:0] j_m1;
   logic [CNT_W-1:0] lcnt_m2;
   logic [CNT_W-1:0] r_p1;
   logic             full;
   logic             odd;
   logic             upper;
   logic             l_avail;
   logic             r_avail;
   logic             take_l;
   logic [DW-1:0]    pop_val;
   logic             scale_ovf;
   state_type        after_load;

   // sorted sample store
   mms_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the one arithmetic unit
   mms_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // index arithmetic
   assign half    = count_ff >> 1;
   assign half_m1 = half - CNT_W'(1);
   assign n_m1    = count_ff - CNT_W'(1);
   assign j_m1    = j_ff - CNT_W'(1);
   assign lcnt_m2 = lcnt_ff - CNT_W'(2);
   assign r_p1    = r_ff + CNT_W'(1);
   assign full    = count_ff == CNT_W'(MAX_SAMPLES);
   assign odd     = count_ff[0];
   assign upper   = mode == mms_pkg::MODE_UPPER;
   assign l_avail = lcnt_ff != '0;
   assign r_avail = r_ff < count_ff;
   assign take_l  = l_avail && (!r_avail || !alu_rsp.flag);
   assign pop_val = take_l ? dl_ff : dr_ff;
   assign scale_ovf = |prod_ff[PROD_W-1:SH+DW-1];
   assign after_load = last_ff ? S_FIN : S_IDLE;

   assign in_ready  = state_ff == S_IDLE;
   assign res_valid = state_ff == S_EMIT;
   assign res_item  = '{result_value: result_ff,
                        sample_count: mms_pkg::COUNT_W'(count_ff),
                        overflowed:   ovf_ff,
                        saturated:    sat_ff};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      sat_in    = sat_ff;
      last_in   = last_ff;
      key_in    = key_ff;
      j_in      = j_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      med_in    = med_ff;
      dl_in     = dl_ff;
      dr_in     = dr_ff;
      lcnt_in   = lcnt_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      dlo_in    = dlo_ff;
      dhi_in    = dhi_ff;
      dm_in     = dm_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      wr_en     = 1'b0;
      wr_addr   = j_ff[ADDR_W-1:0];
      wr_data   = key_ff;
      rd_addr   = j_m1[ADDR_W-1:0];
      alu_req   = '{op: mms_pkg::ALU_GT, a: rd_data, b: key_ff};

      unique case (state_ff)
         // take an item
         S_IDLE: begin
            if (in_valid) begin
               key_in  = in_item.sample;
               last_in = in_item.last;
               j_in    = count_ff;
               if (in_item.has_sample && !full) begin
                  state_in = S_INS_RD;
               end else begin
                  if (in_item.has_sample) begin
                     ovf_in = 1'b1;
                  end
                  state_in = in_item.last ? S_FIN : S_IDLE;
               end
            end
         end
         // insertion: look at the entry below the gap
         S_INS_RD: begin
            if (j_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = after_load;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         // shift larger entry up or drop the key into the gap
         S_INS_CMP: begin
            if (alu_rsp.flag) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               j_in     = j_m1;
               state_in = S_INS_RD;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = after_load;
            end
         end
         // set closed: pick the path
         S_FIN: begin
            sat_in = 1'b0;
            if (mode == mms_pkg::MODE_MAD) begin
               if (count_ff < CNT_W'(2)) begin
                  result_in = '0;
                  state_in  = S_EMIT;
               end else begin
                  state_in = S_MED_RDH;
               end
            end else if (count_ff == '0) begin
               result_in = empty_value;
               state_in  = S_EMIT;
            end else begin
               state_in = S_MED_RDH;
            end
         end
         S_MED_RDH: begin
            rd_addr  = half[ADDR_W-1:0];
            state_in = S_MED_RDL;
         end
         S_MED_RDL: begin
            hi_in    = rd_data;
            rd_addr  = half_m1[ADDR_W-1:0];
            state_in = S_MED_CALC;
         end
         // median of the samples
         S_MED_CALC: begin
            lo_in   = rd_data;
            rd_addr = '0;
            alu_req = '{op: mms_pkg::ALU_MEAN, a: rd_data, b: hi_ff};
            if (odd || upper) begin
               med_in    = hi_ff;
               result_in = hi_ff;
            end else begin
               med_in    = alu_rsp.value;
               result_in = alu_rsp.value;
            end
            state_in = (mode == mms_pkg::MODE_MAD) ? S_DEV_FIRST : S_EMIT;
         end
         // extremes decide whether any deviation clips
         S_DEV_FIRST: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: rd_data, b: med_ff};
            sat_in   = sat_ff | alu_rsp.flag;
            rd_addr  = n_m1[ADDR_W-1:0];
            state_in = S_DEV_LAST;
         end
         S_DEV_LAST: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: rd_data, b: med_ff};
            sat_in   = sat_ff | alu_rsp.flag;
            state_in = S_DEV_LO;
         end
         // heads of the two ascending deviation runs
         S_DEV_LO: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: lo_ff, b: med_ff};
            dl_in    = alu_rsp.value;
            state_in = S_DEV_HI;
         end
         S_DEV_HI: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: hi_ff, b: med_ff};
            dr_in    = alu_rsp.value;
            lcnt_in  = half;
            r_in     = half;
            k_in     = '0;
            state_in = S_POP;
         end
         // merge step: pop the smaller head
         S_POP: begin
            alu_req = '{op: mms_pkg::ALU_GT, a: dl_ff, b: dr_ff};
            if (k_ff == half_m1) begin
               dlo_in = pop_val;
            end
            if (k_ff == half) begin
               dhi_in   = pop_val;
               state_in = S_DMED;
            end else begin
               k_in = k_ff + CNT_W'(1);
               if (take_l) begin
                  lcnt_in = lcnt_ff - CNT_W'(1);
                  rd_addr = lcnt_m2[ADDR_W-1:0];
                  state_in = (lcnt_ff > CNT_W'(1)) ? S_FETCH_L : S_POP;
               end else begin
                  r_in     = r_p1;
                  rd_addr  = r_p1[ADDR_W-1:0];
                  state_in = (r_p1 < count_ff) ? S_FETCH_R : S_POP;
               end
            end
         end
         S_FETCH_L: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: rd_data, b: med_ff};
            dl_in    = alu_rsp.value;
            state_in = S_POP;
         end
         S_FETCH_R: begin
            alu_req  = '{op: mms_pkg::ALU_DEV, a: rd_data, b: med_ff};
            dr_in    = alu_rsp.value;
            state_in = S_POP;
         end
         // median of the deviations
         S_DMED: begin
            alu_req  = '{op: mms_pkg::ALU_MEAN, a: dlo_ff, b: dhi_ff};
            dm_in    = odd ? dhi_ff : alu_rsp.value;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in = PROD_W'(dm_ff) * PROD_W'(mms_pkg::MAD_SCALE)
                    + PROD_W'(mms_pkg::MAD_HALF);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            sat_in    = sat_ff | scale_ovf;
            result_in = scale_ovf ? mms_pkg::SAT_MAX : prod_ff[SH+DW-1:SH];
            state_in  = S_EMIT;
         end
         // hand the result over, then start a new set
         S_EMIT: begin
            if (res_ready) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sat_ff   <= sat_in;
      end
      last_ff   <= last_in;
      key_ff    <= key_in;
      j_ff      <= j_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      med_ff    <= med_in;
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      lcnt_ff   <= lcnt_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      dlo_ff    <= dlo_in;
      dhi_ff    <= dhi_in;
      dm_ff     <= dm_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

endmodule

// ----- design/median_and_mad_sigma.sv -----
// sample item: inserted into the sorted store, each stored entry that is larger moving
// up by one place first; an empty item without last is simply taken
// closing item: after any insert it carries, the median modes read the two middle entries
// and form the median, or take the empty value for an empty set; mad mode then merges the
// deviations of the two sorted halves, paced by the one alu and the single ram read port
// one item in flight at a time; the result register frees the input while a result waits
// reset clears the sample count, the flags, the result valid and the
// configuration registers; the sample store is not cleared
module median_and_mad_sigma #(
   parameter int MAX_SAMPLES = mms_pkg::MAX_SAMPLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mms_pkg::DATA_W-1:0]         req_tdata,   // sample
   input  logic                               req_tuser,   // has_sample
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_value, sample_count, overflowed, saturated, zero fill
   output logic [mms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mms_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [mms_pkg::MODE_W-1:0] mode_ff;
   logic [mms_pkg::DATA_W-1:0] empty_ff;
   logic                       rsp_valid_ff;
   mms_pkg::rsp_item_type      rsp_item_ff;

   mms_pkg::req_item_type in_item;
   mms_pkg::rsp_item_type res_item;
   logic                  res_valid;
   logic                  res_ready;

   assign in_item = '{sample: req_tdata, has_sample: req_tuser, last: req_tlast};

   mms_seq #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_item     (in_item),
      .in_ready    (req_tready),
      .mode        (mode_ff),
      .empty_value (empty_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= mms_pkg::MODE_MEDIAN;
         empty_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            mms_pkg::CSR_STATISTIC_MODE: mode_ff  <= csr_data[mms_pkg::MODE_W-1:0];
            mms_pkg::CSR_EMPTY_VALUE:    empty_ff <= csr_data[mms_pkg::DATA_W-1:0];
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   // result register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_item_ff <= res_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mms_pkg::RSP_DATA_W'({rsp_item_ff.saturated,
                                             rsp_item_ff.overflowed,
                                             rsp_item_ff.sample_count,
                                             rsp_item_ff.result_value});

endmodule
